FILE: src/bps_pkg.sv
// Buzzer pattern sequencer: shared widths, codes, item and stage types.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package bps_pkg;

    localparam int MAX_STEPS  = 16;
    localparam int STEP_W     = 4;
    localparam int STEPS_W    = 5;
    localparam int POWER_W    = 8;
    localparam int PERIOD_W   = 16;
    localparam int REPEAT_W   = 16;
    localparam int SCALE_W    = 7;
    localparam int TICK_W     = 8;
    localparam int PROD_W     = POWER_W + SCALE_W;

    // divide by 100 as multiply by reciprocal, exact for PROD_W-bit products
    localparam int PERCENT     = 100;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + PERCENT - 1) / PERCENT;
    localparam int RECIP_W     = 13;
    localparam int QUOT_W      = PROD_W + RECIP_W;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_ENTRY = 2'd2;

    localparam logic [1:0] INSTR_OFF     = 2'd0;
    localparam logic [1:0] INSTR_ON      = 2'd1;
    localparam logic [1:0] INSTR_PATTERN = 2'd2;

    localparam logic [1:0] CFG_ON_POWER   = 2'd0;
    localparam logic [1:0] CFG_DUTY_SCALE = 2'd1;
    localparam logic [1:0] CFG_TICK_MS    = 2'd2;

    localparam logic [POWER_W-1:0] ON_POWER_RST   = 8'd50;
    localparam logic [SCALE_W-1:0] DUTY_SCALE_RST = 7'd100;
    localparam logic [TICK_W-1:0]  TICK_MS_RST    = 8'd10;

    typedef struct packed {
        logic [1:0]          mode;
        logic [1:0]          instruction;
        logic [REPEAT_W-1:0] repeat_total;
        logic [STEPS_W-1:0]  step_total;
        logic [STEP_W-1:0]   entry_index;
        logic [POWER_W-1:0]  entry_power;
        logic [PERIOD_W-1:0] entry_period;
    } t_item;

    typedef struct packed {
        logic [POWER_W-1:0] on_power;
        logic [SCALE_W-1:0] duty_scale;
        logic [TICK_W-1:0]  tick_ms;
    } t_cfg;

    // hand-off from the step stage to the scaling stage
    typedef struct packed {
        logic              upd;
        logic [PROD_W-1:0] product;
        logic              playing;
        logic [STEP_W-1:0] step_now;
    } t_mid;

    function automatic logic has_result(input logic [1:0] mode);
        return (mode == MODE_TICK) || (mode == MODE_START);
    endfunction

endpackage

FILE: src/bps_step.sv
// Buzzer pattern sequencer: sequencing state, step table and raw power product.
// Depends on bps_pkg.
`timescale 1ns / 1ps

module bps_step
    import bps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_mid  o_mid
);

    logic [1:0]          r_instr, e_instr;
    logic [PERIOD_W-1:0] r_elapsed, e_elapsed, n_elapsed;
    logic [STEP_W-1:0]   r_step, e_step, n_step;
    logic [REPEAT_W-1:0] r_rep_left, e_rep_left, n_rep_left;
    logic [REPEAT_W-1:0] r_rep_set, e_rep_set;
    logic [STEPS_W-1:0]  r_steps, e_steps;
    logic [POWER_W-1:0]  r_pow_tab [MAX_STEPS];
    logic [PERIOD_W-1:0] r_per_tab [MAX_STEPS];

    logic                upd;
    logic [POWER_W-1:0]  power;
    logic [PERIOD_W:0]   sum;
    logic [PERIOD_W-1:0] sum_sat;
    logic [STEPS_W-1:0]  step_inc;

    always_comb begin
        e_instr    = r_instr;
        e_elapsed  = r_elapsed;
        e_step     = r_step;
        e_rep_left = r_rep_left;
        e_rep_set  = r_rep_set;
        e_steps    = r_steps;
        if (i_item.mode == MODE_START) begin
            e_instr    = i_item.instruction;
            e_elapsed  = '0;
            e_step     = '0;
            e_rep_left = i_item.repeat_total;
            e_rep_set  = i_item.repeat_total;
            e_steps    = (i_item.step_total > STEPS_W'(MAX_STEPS)) ?
                         STEPS_W'(MAX_STEPS) : i_item.step_total;
        end

        n_elapsed  = e_elapsed;
        n_step     = e_step;
        n_rep_left = e_rep_left;
        upd        = 1'b0;
        power      = '0;
        sum        = {1'b0, e_elapsed} + (PERIOD_W + 1)'(i_cfg.tick_ms);
        sum_sat    = sum[PERIOD_W] ? '1 : sum[PERIOD_W-1:0];
        step_inc   = {1'b0, e_step} + STEPS_W'(1);

        case (e_instr)
            INSTR_OFF: begin
                upd = 1'b1;
            end
            INSTR_ON: begin
                upd   = 1'b1;
                power = i_cfg.on_power;
            end
            INSTR_PATTERN: begin
                if (e_rep_left != '0) begin
                    upd       = (e_elapsed == '0);
                    power     = r_pow_tab[e_step];
                    n_elapsed = sum_sat;
                    if (sum_sat >= r_per_tab[e_step]) begin
                        n_elapsed = '0;
                        n_step    = step_inc[STEP_W-1:0];
                        if (step_inc >= e_steps) begin
                            n_step = '0;
                            if (e_rep_set != '0)
                                n_rep_left = e_rep_left - REPEAT_W'(1);
                        end
                    end
                end
            end
            default: ;  // unknown instruction holds everything
        endcase
    end

    assign o_mid.upd      = upd;
    assign o_mid.product  = PROD_W'(power) * PROD_W'(i_cfg.duty_scale);
    assign o_mid.playing  = (e_instr == INSTR_PATTERN) && (n_rep_left != '0);
    assign o_mid.step_now = n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_instr    <= INSTR_OFF;
            r_elapsed  <= '0;
            r_step     <= '0;
            r_rep_left <= '0;
            r_rep_set  <= '0;
            r_steps    <= '0;
            for (int i = 0; i < MAX_STEPS; i++) begin
                r_pow_tab[i] <= '0;
                r_per_tab[i] <= '0;
            end
        end else if (i_en) begin
            if (has_result(i_item.mode)) begin
                r_instr    <= e_instr;
                r_elapsed  <= n_elapsed;
                r_step     <= n_step;
                r_rep_left <= n_rep_left;
                r_rep_set  <= e_rep_set;
                r_steps    <= e_steps;
            end else if (i_item.mode == MODE_ENTRY) begin
                r_pow_tab[i_item.entry_index] <= i_item.entry_power;
                r_per_tab[i_item.entry_index] <= i_item.entry_period;
            end
        end
    end

endmodule

FILE: src/bps_scale.sv
// Buzzer pattern sequencer: percent scaling of the power product and held duty.
// Depends on bps_pkg.
`timescale 1ns / 1ps

module bps_scale
    import bps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_mid               i_mid,
    output logic [POWER_W-1:0] o_duty
);

    logic [POWER_W-1:0] r_held_duty, n_held_duty;
    logic [QUOT_W-1:0]  recip_prod;
    logic [PROD_W-1:0]  quot;
    logic [POWER_W-1:0] quot_sat;

    assign recip_prod = QUOT_W'(i_mid.product) * QUOT_W'(RECIP_MUL);
    assign quot       = PROD_W'(recip_prod >> RECIP_SHIFT);
    assign quot_sat   = (quot > PROD_W'(255)) ? '1 : quot[POWER_W-1:0];

    assign n_held_duty = i_mid.upd ? quot_sat : r_held_duty;
    assign o_duty      = n_held_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_duty <= '0;
        end else if (i_en) begin
            r_held_duty <= n_held_duty;
        end
    end

endmodule

FILE: src/buzzer_pattern_sequencer.sv
// Buzzer pattern sequencer top level: handshakes, config registers, pipeline.
// Depends on bps_pkg, bps_step, bps_scale.
//
//  channel   | ports                             | payload
//  ----------+-----------------------------------+---------------------------------
//  input     | i_s_tvalid / o_s_tready           | tuser mode, tdata item fields
//  result    | o_m_tvalid / i_m_tready           | tdata duty, playing, step_now
//  config    | i_cfg_valid / o_cfg_ready         | i_cfg_index, i_cfg_data
//
// One word per cycle sustained while result words are taken. A result passes through the
// input register, step stage register and scaled output register. Table writes and mode 3
// words leave after the input register with no result. Synchronous active-low reset clears
// the valid flags, config registers, sequencing state, held duty and step table, but not the
// payload registers. A stalled result holds; upstream keeps flowing until the stages fill.
`timescale 1ns / 1ps

module buzzer_pattern_sequencer
    import bps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [1:0] mode
    input  logic [1:0]            i_s_tuser,
    // [1:0] instruction, [17:2] repeat_total, [22:18] step_total,
    // [26:23] entry_index, [34:27] entry_power, [50:35] entry_period, rest zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [7:0] duty, [8] playing, [12:9] step_now, rest zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data
);

    t_cfg  r_cfg;
    t_item r_in, in_item;
    logic  r_in_valid;
    t_mid  r_mid, mid;
    logic  r_mid_valid;
    logic  [POWER_W-1:0] r_duty, duty;
    logic  r_playing;
    logic  [STEP_W-1:0]  r_step_now;
    logic  r_out_valid;

    logic out_free, mid_free, mid_adv, in_adv, in_res;

    assign in_item.mode         = i_s_tuser;
    assign in_item.instruction  = i_s_tdata[1:0];
    assign in_item.repeat_total = i_s_tdata[17:2];
    assign in_item.step_total   = i_s_tdata[22:18];
    assign in_item.entry_index  = i_s_tdata[26:23];
    assign in_item.entry_power  = i_s_tdata[34:27];
    assign in_item.entry_period = i_s_tdata[50:35];

    assign out_free   = !r_out_valid || i_m_tready;
    assign mid_adv    = r_mid_valid && out_free;
    assign mid_free   = !r_mid_valid || out_free;
    assign in_res     = has_result(r_in.mode);
    assign in_adv     = r_in_valid && (mid_free || !in_res);
    assign o_s_tready = !r_in_valid || in_adv;
    assign o_cfg_ready = 1'b1;

    bps_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_adv),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_mid   (mid)
    );

    bps_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (mid_adv),
        .i_mid   (r_mid),
        .o_duty  (duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_power   <= ON_POWER_RST;
            r_cfg.duty_scale <= DUTY_SCALE_RST;
            r_cfg.tick_ms    <= TICK_MS_RST;
            r_in_valid       <= 1'b0;
            r_mid_valid      <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ON_POWER:   r_cfg.on_power   <= i_cfg_data;
                    CFG_DUTY_SCALE: r_cfg.duty_scale <= i_cfg_data[SCALE_W-1:0];
                    CFG_TICK_MS:    r_cfg.tick_ms    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_s_tready)
                r_in_valid <= i_s_tvalid;
            if (mid_free)
                r_mid_valid <= in_adv && in_res;
            if (out_free)
                r_out_valid <= mid_adv;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid)
            r_in <= in_item;
        if (in_adv && in_res)
            r_mid <= mid;
        if (mid_adv) begin
            r_duty     <= duty;
            r_playing  <= r_mid.playing;
            r_step_now <= r_mid.step_now;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_step_now, r_playing, r_duty};

endmodule

FILE: tb/tb_buzzer_pattern_sequencer.sv
// Self-checking testbench for buzzer_pattern_sequencer: directed and random stream traffic,
// checked word by word against an in-bench model of the duty/step sequencer.
// Depends on bps_pkg and the buzzer_pattern_sequencer RTL only.
`timescale 1ns / 1ps

module tb_buzzer_pattern_sequencer;
    import bps_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [1:0] INSTR_UNKNOWN = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_PHASE = 320;

    typedef struct packed {
        logic [POWER_W-1:0] duty;
        logic               playing;
        logic [STEP_W-1:0]  step_now;
    } t_drive;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [1:0]            s_user = '0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  m_ready = 1'b1;
    logic                  cfg_valid = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [7:0]            cfg_data = '0;
    wire                   o_s_tready;
    wire                   o_m_tvalid;
    wire [OUT_DATA_W-1:0]  o_m_tdata;
    wire                   o_cfg_ready;

    buzzer_pattern_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (s_user),
        .i_s_tdata   (s_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // sequencer model state
    logic [POWER_W-1:0]  cfg_on_power = ON_POWER_RST;
    logic [SCALE_W-1:0]  cfg_scale    = DUTY_SCALE_RST;
    logic [TICK_W-1:0]   cfg_tick     = TICK_MS_RST;
    logic [POWER_W-1:0]  mdl_duty     = '0;
    logic [1:0]          mdl_instr    = INSTR_OFF;
    logic [PERIOD_W-1:0] mdl_elapsed  = '0;
    logic [STEP_W-1:0]   mdl_step     = '0;
    logic [REPEAT_W-1:0] mdl_left     = '0;
    logic [REPEAT_W-1:0] mdl_repeats  = '0;
    logic [STEPS_W-1:0]  mdl_steps    = '0;
    logic [POWER_W-1:0]  power_tbl [MAX_STEPS];
    logic [PERIOD_W-1:0] period_tbl [MAX_STEPS];

    t_drive expected_drive [$];
    t_drive want_drive;
    t_drive got_drive;
    int     fail_cnt = 0;
    int     cycle_cnt = 0;
    int     sent_cnt = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;

    initial begin
        for (int i = 0; i < MAX_STEPS; i++) begin
            power_tbl[i]  = '0;
            period_tbl[i] = '0;
        end
    end

    function automatic logic [POWER_W-1:0] scaled_power(input logic [POWER_W-1:0] pwr);
        int unsigned prod;
        prod = (int'(pwr) * int'(cfg_scale)) / PERCENT;
        return (prod > 255) ? 8'd255 : prod[POWER_W-1:0];
    endfunction

    // one step of whatever instruction is active
    function automatic void run_sequencer();
        int unsigned sum;
        int unsigned nxt;
        logic [STEP_W-1:0] idx;
        if (mdl_instr == INSTR_OFF) begin
            mdl_duty = '0;
        end else if (mdl_instr == INSTR_ON) begin
            mdl_duty = scaled_power(cfg_on_power);
        end else if (mdl_instr == INSTR_PATTERN && mdl_left != 0) begin
            idx = mdl_step;
            if (mdl_elapsed == 0)
                mdl_duty = scaled_power(power_tbl[idx]);
            sum = int'(mdl_elapsed) + int'(cfg_tick);
            mdl_elapsed = (sum > 65535) ? 16'hFFFF : sum[PERIOD_W-1:0];
            if (mdl_elapsed >= period_tbl[idx]) begin
                mdl_elapsed = '0;
                nxt = int'(idx) + 1;
                if (nxt >= int'(mdl_steps)) begin
                    mdl_step = '0;
                    if (mdl_repeats != 0 && mdl_left != 0)
                        mdl_left = mdl_left - 16'd1;
                end else begin
                    mdl_step = nxt[STEP_W-1:0];
                end
            end
        end
    endfunction

    function automatic void predict_drive(input t_item it);
        t_drive res;
        if (it.mode == MODE_ENTRY) begin
            power_tbl[it.entry_index]  = it.entry_power;
            period_tbl[it.entry_index] = it.entry_period;
        end else if (it.mode == MODE_TICK || it.mode == MODE_START) begin
            if (it.mode == MODE_START) begin
                mdl_instr   = it.instruction;
                mdl_repeats = it.repeat_total;
                mdl_left    = it.repeat_total;
                mdl_steps   = (it.step_total > MAX_STEPS) ? STEPS_W'(MAX_STEPS) : it.step_total;
                mdl_step    = '0;
                mdl_elapsed = '0;
            end
            run_sequencer();
            res.duty     = mdl_duty;
            res.playing  = (mdl_instr == INSTR_PATTERN) && (mdl_left != 0);
            res.step_now = mdl_step;
            expected_drive.push_back(res);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (rst_n && o_m_tvalid && m_ready) begin
            got_drive.duty     = o_m_tdata[7:0];
            got_drive.playing  = o_m_tdata[8];
            got_drive.step_now = o_m_tdata[12:9];
            if (expected_drive.size() == 0) begin
                $error("result word with nothing expected: tdata %h", o_m_tdata);
                fail_cnt++;
            end else begin
                want_drive = expected_drive.pop_front();
                if (got_drive.duty !== want_drive.duty) begin
                    $error("duty: expected %0d, got %0d", want_drive.duty, got_drive.duty);
                    fail_cnt++;
                end
                if (got_drive.playing !== want_drive.playing) begin
                    $error("playing: expected %0d, got %0d", want_drive.playing,
                           got_drive.playing);
                    fail_cnt++;
                end
                if (got_drive.step_now !== want_drive.step_now) begin
                    $error("step_now: expected %0d, got %0d", want_drive.step_now,
                           got_drive.step_now);
                    fail_cnt++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_item mk_tick();
        t_item it;
        it = '0;
        it.mode = MODE_TICK;
        return it;
    endfunction

    function automatic t_item mk_start(input logic [1:0] instr, input logic [15:0] reps,
                                       input logic [4:0] steps);
        t_item it;
        it = '0;
        it.mode         = MODE_START;
        it.instruction  = instr;
        it.repeat_total = reps;
        it.step_total   = steps;
        return it;
    endfunction

    function automatic t_item mk_entry(input logic [3:0] idx, input logic [7:0] pwr,
                                       input logic [15:0] per);
        t_item it;
        it = '0;
        it.mode         = MODE_ENTRY;
        it.entry_index  = idx;
        it.entry_power  = pwr;
        it.entry_period = per;
        return it;
    endfunction

    function automatic t_item mk_noise();
        t_item it;
        it.mode         = 2'($urandom_range(0, 3));
        it.instruction  = 2'($urandom_range(0, 3));
        it.repeat_total = 16'($urandom_range(0, 65535));
        it.step_total   = 5'($urandom_range(0, 31));
        it.entry_index  = 4'($urandom_range(0, 15));
        it.entry_power  = 8'($urandom_range(0, 255));
        it.entry_period = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance with tvalid still high
    task automatic send_word(input t_item it);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= it.mode;
        s_data  <= {5'b0, it.entry_period, it.entry_power, it.entry_index,
                    it.step_total, it.repeat_total, it.instruction};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_drive(it);
        if (it.mode != MODE_UNUSED)
            sent_cnt++;
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (expected_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ON_POWER:   cfg_on_power = val;
            CFG_DUTY_SCALE: cfg_scale    = val[SCALE_W-1:0];
            CFG_TICK_MS:    cfg_tick     = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [7:0] pwr, input logic [7:0] scale,
                                input logic [7:0] tick);
        drain_pipeline();
        write_reg(CFG_ON_POWER, pwr);
        write_reg(CFG_DUTY_SCALE, scale);
        write_reg(CFG_TICK_MS, tick);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 16'(int'(cfg_tick) * $urandom_range(0, 3));
        else if (r < 9)
            return 16'($urandom_range(0, 65535));
        else
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic logic [15:0] pick_repeats();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'($urandom_range(1, 3));
        else if (r < 8)
            return 16'd0;
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [4:0] pick_steps();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 5'($urandom_range(1, 5));
        else if (r < 8)
            return 5'd0;
        else
            return 5'($urandom_range(0, 31));
    endfunction

    task automatic test_reset_state();
        t_item junk;
        send_word(mk_tick());
        junk = mk_noise();
        junk.mode = MODE_UNUSED;
        send_word(junk);
        send_word(mk_start(INSTR_ON, 16'd0, 5'd0));
        send_word(mk_start(INSTR_UNKNOWN, 16'hFFFF, 5'd31));
        send_word(mk_tick());
    endtask

    task automatic test_pattern_corners();
        send_word(mk_entry(4'd0, 8'd255, 16'd0));
        send_word(mk_entry(4'd1, 8'd7, 16'd20));
        send_word(mk_entry(4'd2, 8'd128, 16'd10));
        send_word(mk_entry(4'd15, 8'd200, 16'hFFFF));
        // zero repeat total: duty left where the on instruction put it
        send_word(mk_start(INSTR_PATTERN, 16'd0, 5'd3));
        // zero step total: every advance wraps and uses up a repeat
        send_word(mk_start(INSTR_PATTERN, 16'd2, 5'd0));
        repeat (2) send_word(mk_tick());
        send_word(mk_start(INSTR_PATTERN, 16'd2, 5'd3));
        repeat (6) send_word(mk_tick());
        // step total above table depth gets capped
        send_word(mk_start(INSTR_PATTERN, 16'hFFFF, 5'd31));
        repeat (3) send_word(mk_tick());
        send_word(mk_start(INSTR_OFF, 16'd0, 5'd0));
        send_word(mk_tick());
    endtask

    task automatic test_config_extremes();
        apply_config(8'd255, 8'd127, 8'd255);
        send_word(mk_start(INSTR_ON, 16'd0, 5'd0));
        send_word(mk_tick());
        apply_config(8'd0, 8'd0, 8'd1);
        send_word(mk_start(INSTR_ON, 16'd0, 5'd0));
        send_word(mk_start(INSTR_PATTERN, 16'd1, 5'd2));
        send_word(mk_tick());
    endtask

    // last slot has the longest period, so elapsed time runs into its ceiling
    task automatic test_elapsed_saturation();
        apply_config(8'd200, 8'd99, 8'd254);
        send_word(mk_start(INSTR_PATTERN, 16'd1, 5'd16));
        repeat (290) send_word(mk_tick());
    endtask

    task automatic send_random_burst();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_word(mk_entry(4'($urandom_range(0, 3) ? $urandom_range(0, 5)
                                                           : $urandom_range(0, 15)),
                                   8'($urandom_range(0, 255)), pick_period()));
            send_word(mk_start(INSTR_PATTERN, pick_repeats(), pick_steps()));
            n = $urandom_range(3, 25);
            repeat (n) send_word(mk_tick());
        end else if (kind < 75) begin
            send_word(mk_start(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                               5'($urandom_range(0, 31))));
            n = $urandom_range(1, 6);
            repeat (n) send_word(mk_tick());
        end else if (kind < 90) begin
            n = $urandom_range(1, 5);
            repeat (n) send_word(mk_noise());
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) send_word(mk_tick());
        end
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input logic [7:0] pwr,
                                       input logic [7:0] scale, input logic [7:0] tick);
        int target;
        apply_config(pwr, scale, tick);
        idle_pct  = idle;
        stall_pct = stall;
        target = sent_cnt + ITEMS_PER_PHASE;
        while (sent_cnt < target) send_random_burst();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_pattern_corners();
        test_config_extremes();
        test_elapsed_saturation();
        test_random_traffic(0, 0, 8'd255, 8'd100, 8'd1);
        test_random_traffic(53, 0, 8'd0, 8'd1, 8'd255);
        test_random_traffic(0, 53, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 100)),
                            8'($urandom_range(1, 255)));
        test_random_traffic(37, 37, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 127)),
                            8'($urandom_range(1, 255)));

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
